@@ hdl/optab_pkg.sv @@
// Shared types, constants and codes for the object pointer registry table.
`timescale 1ns / 1ps
`default_nettype none

package optab_pkg;

    localparam int DEF_ENTRIES      = 128;
    localparam int DEF_POINTER_BITS = 32;
    localparam int DEF_TYPE_BITS    = 4;
    localparam int OP_BITS          = 2;
    localparam int COUNT_OUT_BITS   = 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_REGISTER   = 2'd0,
        OP_DEREGISTER = 2'd1,
        OP_VALIDATE   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_APPEND,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // load the request word, clear index and flag
        logic idx_inc;
        logic rd_en;
        logic rd_next;     // read at index + 1 instead of index
        logic wr_append;   // write the request pair at the live count
        logic wr_shift;    // write the last read entry at the index
        logic cnt_inc;
        logic cnt_dec;
        logic ok_set;
        logic rsp_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               ptr_null;
        logic               full;
        logic               idx_at_end;  // index equals live count
        logic               shift_end;   // index + 1 equals live count
        logic               match;       // read entry equals request pair
        logic               out_free;    // response register can take a word
    } ctrl_sts_t;

endpackage

`default_nettype wire

@@ hdl/optab_if.sv @@
// Request and response channel interfaces of the object pointer registry table.
`timescale 1ns / 1ps
`default_nettype none

interface optab_req_if #(
    parameter int POINTER_BITS = optab_pkg::DEF_POINTER_BITS,
    parameter int TYPE_BITS    = optab_pkg::DEF_TYPE_BITS
);
    import optab_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_BITS-1:0]      op;
    logic [POINTER_BITS-1:0] obj_pointer;
    logic [TYPE_BITS-1:0]    obj_type;

    modport source (output valid, output op, output obj_pointer, output obj_type,
                    input ready);
    modport sink   (input valid, input op, input obj_pointer, input obj_type,
                    output ready);
endinterface

interface optab_rsp_if;
    import optab_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [COUNT_OUT_BITS-1:0] entry_count;

    modport source (output valid, output ok, output entry_count, input ready);
    modport sink   (input valid, input ok, input entry_count, output ready);
endinterface

`default_nettype wire

@@ hdl/optab_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module optab_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 128,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

`default_nettype wire

@@ hdl/optab_ctrl.sv @@
// Controller state machine: sequences scan, append and compaction steps.
`timescale 1ns / 1ps
`default_nettype none

module optab_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire optab_pkg::ctrl_sts_t  sts,
    output optab_pkg::ctrl_cmd_t       cmd
);
    import optab_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.ptr_null)
                begin
                    state_next = ST_RESP;
                end
                else if (sts.op == OP_REGISTER)
                begin
                    // A full table refuses even a pair that is already present.
                    state_next = sts.full ? ST_RESP : ST_SCAN_RD;
                end
                else if (sts.op == OP_DEREGISTER || sts.op == OP_VALIDATE)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.idx_at_end)
                begin
                    state_next = (sts.op == OP_REGISTER) ? ST_APPEND : ST_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    if (sts.op == OP_DEREGISTER)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        cmd.ok_set = 1'b1;
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_APPEND:
            begin
                cmd.wr_append = 1'b1;
                cmd.cnt_inc   = 1'b1;
                cmd.ok_set    = 1'b1;
                state_next    = ST_RESP;
            end
            ST_SHIFT_RD:
            begin
                if (sts.shift_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.ok_set  = 1'b1;
                    state_next  = ST_RESP;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

@@ hdl/optab_dp.sv @@
// Datapath: request registers, index and count, entry RAM and response register.
`timescale 1ns / 1ps
`default_nettype none

module optab_dp #(
    parameter int ENTRIES      = optab_pkg::DEF_ENTRIES,
    parameter int POINTER_BITS = optab_pkg::DEF_POINTER_BITS,
    parameter int TYPE_BITS    = optab_pkg::DEF_TYPE_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [optab_pkg::OP_BITS-1:0] op,
    input  wire logic [POINTER_BITS-1:0]      obj_pointer,
    input  wire logic [TYPE_BITS-1:0]         obj_type,
    input  wire optab_pkg::ctrl_cmd_t         cmd,
    output optab_pkg::ctrl_sts_t              sts,
    optab_rsp_if.source                       rsp
);
    import optab_pkg::*;

    localparam int ADDR_BITS  = $clog2(ENTRIES);
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);
    localparam int WORD_BITS  = POINTER_BITS + TYPE_BITS;

    logic [OP_BITS-1:0]        op_reg;
    logic [POINTER_BITS-1:0]   ptr_reg;
    logic [TYPE_BITS-1:0]      type_reg;
    logic [COUNT_BITS-1:0]     idx_reg;
    logic [COUNT_BITS-1:0]     count_reg;
    logic                      ok_reg;
    logic                      rsp_valid_reg;
    logic                      rsp_ok_reg;
    logic [COUNT_OUT_BITS-1:0] rsp_count_reg;

    logic [COUNT_BITS-1:0]                idx_plus;
    logic [ADDR_BITS-1:0]                 rd_addr;
    logic [ADDR_BITS-1:0]                 wr_addr;
    logic [WORD_BITS-1:0]                 wr_data;
    logic [WORD_BITS-1:0]                 rd_data;
    logic [COUNT_BITS+COUNT_OUT_BITS-1:0] count_wide;
    logic                                 count_dec_sel;

    assign idx_plus = idx_reg + COUNT_BITS'(1);

    // Index + 1 stays below the live count here, so it fits the address.
    assign rd_addr = cmd.rd_next ? idx_plus[ADDR_BITS-1:0] : idx_reg[ADDR_BITS-1:0];
    assign wr_addr = cmd.wr_append ? count_reg[ADDR_BITS-1:0] : idx_reg[ADDR_BITS-1:0];
    assign wr_data = cmd.wr_append ? {ptr_reg, type_reg} : rd_data;

    optab_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ENTRIES)
    ) u_entries (
        .clk     (clk),
        .wr_en   (cmd.wr_append | cmd.wr_shift),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            ptr_reg  <= obj_pointer;
            type_reg <= obj_type;
        end
        if (cmd.rsp_load)
        begin
            rsp_ok_reg    <= ok_reg;
            rsp_count_reg <= count_wide[COUNT_OUT_BITS-1:0];
        end
    end

    assign count_dec_sel = cmd.cnt_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg <= '0;
                ok_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_plus;
                end
                if (cmd.ok_set)
                begin
                    ok_reg <= 1'b1;
                end
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            else if (count_dec_sel)
            begin
                count_reg <= count_reg - COUNT_BITS'(1);
            end
            if (cmd.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign count_wide = {{COUNT_OUT_BITS{1'b0}}, count_reg};

    assign sts.op         = op_reg;
    assign sts.ptr_null   = (ptr_reg == '0);
    assign sts.full       = (count_reg == COUNT_BITS'(ENTRIES));
    assign sts.idx_at_end = (idx_reg == count_reg);
    assign sts.shift_end  = (idx_plus == count_reg);
    assign sts.match      = (rd_data == {ptr_reg, type_reg});
    assign sts.out_free   = !rsp_valid_reg || rsp.ready;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.entry_count = rsp_count_reg;
endmodule

`default_nettype wire

@@ hdl/object_pointer_registry_table.sv @@
// Operation: unless the pointer is null or a register meets a full table, a request
// is compared with each live entry in turn; a register that reaches the live count
// appends the pair, and a deregister that finds its pair shifts later entries down.
// Throughput: one request word at a time; the next is accepted once the response
// word is loaded into the output register, which holds it until the sink takes it.
// Reset clears the live count and the handshake; the entry RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module object_pointer_registry_table #(
    parameter int ENTRIES      = optab_pkg::DEF_ENTRIES,
    parameter int POINTER_BITS = optab_pkg::DEF_POINTER_BITS,
    parameter int TYPE_BITS    = optab_pkg::DEF_TYPE_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    optab_req_if.sink   req,
    optab_rsp_if.source rsp
);
    import optab_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      ready;

    assign req.ready = ready;

    optab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    optab_dp #(
        .ENTRIES      (ENTRIES),
        .POINTER_BITS (POINTER_BITS),
        .TYPE_BITS    (TYPE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (req.op),
        .obj_pointer (req.obj_pointer),
        .obj_type    (req.obj_type),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp)
    );
endmodule

`default_nettype wire
